### rtl/core/dpm_pkg.sv
// ============================================================================
// dpm_pkg
// Constants and elaboration-time table functions for the dew point pipeline.
// ============================================================================
package dpm_pkg;

    localparam int LOG_TABLE_DEPTH_DEF = 256;
    localparam int MAG_A_Q16           = 1131807;
    localparam int MAG_B_Q8            = 60851;
    localparam int LN2_Q16             = 45426;
    localparam int RH_MIN_Q8           = 256;
    localparam int RH_MAX_Q8           = 25600;
    localparam int DEW_MIN_Q8          = -25600;
    localparam int DEW_MAX_Q8          = 33280;

    // Restoring long division, used only at elaboration to compute log table entries.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry i of the table: ln(1 + i/d) in Q16, from the series of 2*atanh(i/(2d+i)).
    function automatic logic [15:0] ln_rom_entry(input int i, input int d);
        logic [63:0] z;
        logic [63:0] zz;
        logic [63:0] term;
        logic [63:0] sum;
        z    = udiv64(64'(i) << 32, 64'(2 * d + i));
        zz   = (z * z) >> 32;
        term = z;
        sum  = '0;
        for (int k = 1; k < 256; k += 2)
        begin
            if (term != 64'd0)
            begin
                sum  = sum + udiv64(term, 64'(k));
                term = (term * zz) >> 32;
            end
        end
        return 16'((64'd2 * sum + 64'd32768) >> 16);
    endfunction

    // Interpolated natural log in Q16 of a Q8 humidity, evaluated at elaboration.
    function automatic int ln_q16_const(input int h, input int d);
        logic [31:0] hv;
        logic [63:0] frac;
        logic [63:0] p;
        logic [63:0] base;
        logic [63:0] diff;
        int          e;
        int          idx;
        hv = 32'(h);
        e  = 14;
        for (int b = 14; b > 8; b--)
        begin
            if (e == b && hv[b] == 1'b0)
            begin
                e = b - 1;
            end
        end
        frac = ((64'(hv) << 16) >> e) - 64'd65536;
        p    = frac * 64'(d);
        idx  = int'(p >> 16);
        base = 64'(ln_rom_entry(idx, d));
        diff = 64'(ln_rom_entry(idx + 1, d)) - base;
        return e * LN2_Q16 + int'(base) + int'((diff * (p & 64'hFFFF) + 64'd32768) >> 16);
    endfunction

endpackage

### rtl/core/dpm_div.sv
// ============================================================================
// dpm_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// ============================================================================
module dpm_div
    import dpm_pkg::*;
#(
    parameter int NUM_W  = 36,
    parameter int DEN_W  = 17,
    parameter int QUO_W  = 21,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);

    logic              vld_reg  [QUO_W+1];
    logic [DEN_W-1:0]  rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]  lo_reg   [QUO_W+1];
    logic [DEN_W-1:0]  den_reg  [QUO_W+1];
    logic [SIDE_W-1:0] side_reg [QUO_W+1];

    // The quotient is known to fit, so the upper numerator bits are below the divisor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= DEN_W'(num >> QUO_W);
        lo_reg[0]   <= num[QUO_W-1:0];
        den_reg[0]  <= den;
        side_reg[0] <= side;
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] lo_next;

        always_comb
        begin
            trial    = {rem_reg[k], lo_reg[k][QUO_W-1]};
            ge       = (trial >= {1'b0, den_reg[k]});
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg[k]}) : trial[DEN_W-1:0];
            lo_next  = {lo_reg[k][QUO_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            lo_reg[k+1]   <= lo_next;
            den_reg[k+1]  <= den_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign quo       = lo_reg[QUO_W];
    assign side_out  = side_reg[QUO_W];

endmodule

### rtl/core/dew_point_magnus.sv
// ============================================================================
// dew_point_magnus
// Magnus-formula dew point from temperature and relative humidity, Q8 fixed point.
// ============================================================================
//  Channel   Signals                          Direction  Handshake
//  request   start, temperature, humidity     in         taken when start and not busy
//  result    done, dew_point                  out        one-cycle strobe, no back-pressure
//
// A new request can be taken in every cycle; busy is always low.
// The pipeline runs log lookup and multiply, the first divider, the stages that form
// gamma, the second divider, and then an output register.
// The two dividers, one quotient bit per stage, set the depth.
// Reset clears only the valid bits; no results are lost since none are held back.
// ============================================================================
module dew_point_magnus
    import dpm_pkg::*;
#(
    parameter int LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] temperature,
    input  logic [14:0]        humidity,
    output logic               done,
    output logic signed [16:0] dew_point
);

    localparam int IDX_W = $clog2(LOG_TABLE_DEPTH);
    localparam int PW    = 16 + IDX_W;

    localparam logic signed [21:0] MAG_A_S  = 22'(MAG_A_Q16);
    localparam logic signed [16:0] MAG_B_S  = 17'(MAG_B_Q8);
    localparam logic signed [20:0] LN_MAX_S = 21'(ln_q16_const(RH_MAX_Q8, LOG_TABLE_DEPTH));
    localparam logic signed [17:0] DEW_MIN_S = 18'(DEW_MIN_Q8);
    localparam logic signed [17:0] DEW_MAX_S = 18'(DEW_MAX_Q8);

    logic [15:0] rom_lo   [LOG_TABLE_DEPTH];
    logic [15:0] rom_diff [LOG_TABLE_DEPTH];

    for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++)
    begin : g_rom
        localparam logic [15:0] LO = ln_rom_entry(gi, LOG_TABLE_DEPTH);
        localparam logic [15:0] HI = ln_rom_entry(gi + 1, LOG_TABLE_DEPTH);
        assign rom_lo[gi]   = LO;
        assign rom_diff[gi] = HI - LO;
    end

    // Stage 1: clamp the humidity.
    logic               s1_vld_reg;
    logic signed [15:0] s1_temp_reg;
    logic [14:0]        s1_hum_reg;
    logic [14:0]        s1_hum_next;

    // Stage 2: a*T product, divisor, log exponent and mantissa.
    logic               s2_vld_reg;
    logic signed [36:0] s2_prod_reg;
    logic [16:0]        s2_den_reg;
    logic [3:0]         s2_exp_reg;
    logic [15:0]        s2_frac_reg;
    logic [3:0]         s2_exp_next;
    logic [15:0]        s2_frac_next;
    logic [31:0]        s2_shift;
    logic [17:0]        s2_den_sum;

    // Stage 3: rounded magnitude for the first division, table position.
    logic               s3_vld_reg;
    logic [35:0]        s3_num_reg;
    logic [16:0]        s3_den_reg;
    logic               s3_sign_reg;
    logic [3:0]         s3_exp_reg;
    logic [PW-1:0]      s3_pos_reg;
    logic [35:0]        s3_abs;

    // Stage 4: table read.
    logic               s4_vld_reg;
    logic [35:0]        s4_num_reg;
    logic [16:0]        s4_den_reg;
    logic               s4_sign_reg;
    logic [3:0]         s4_exp_reg;
    logic [15:0]        s4_base_reg;
    logic [15:0]        s4_diff_reg;
    logic [15:0]        s4_rem_reg;
    logic [IDX_W-1:0]   s4_idx;

    // Stage 5: interpolation product.
    logic               s5_vld_reg;
    logic [35:0]        s5_num_reg;
    logic [16:0]        s5_den_reg;
    logic               s5_sign_reg;
    logic [3:0]         s5_exp_reg;
    logic [15:0]        s5_base_reg;
    logic [31:0]        s5_interp_reg;

    // Stage 6: ln(RH/100).
    logic               s6_vld_reg;
    logic [35:0]        s6_num_reg;
    logic [16:0]        s6_den_reg;
    logic               s6_sign_reg;
    logic signed [20:0] s6_lnr_reg;
    logic [20:0]        s6_ln_sum;

    // First divider.
    logic               d1_vld;
    logic [20:0]        d1_quo;
    logic [21:0]        d1_side;

    // Stage 7: gamma.
    logic               s7_vld_reg;
    logic signed [22:0] s7_gamma_reg;
    logic signed [22:0] s7_term;

    // Stage 8: b*gamma and a - gamma.
    logic               s8_vld_reg;
    logic signed [38:0] s8_prod_reg;
    logic [21:0]        s8_den_reg;
    logic signed [23:0] s8_den_diff;

    // Stage 9: rounded magnitude for the second division.
    logic               s9_vld_reg;
    logic [37:0]        s9_num_reg;
    logic [21:0]        s9_den_reg;
    logic               s9_sign_reg;
    logic [37:0]        s9_abs;

    // Second divider and output.
    logic               d2_vld;
    logic [16:0]        d2_quo;
    logic               d2_side;
    logic signed [17:0] dew_full;
    logic signed [16:0] dew_next;
    logic               done_reg;
    logic signed [16:0] dew_reg;

    assign busy = 1'b0;

    always_comb
    begin
        if (humidity < 15'(RH_MIN_Q8))
        begin
            s1_hum_next = 15'(RH_MIN_Q8);
        end
        else if (humidity > 15'(RH_MAX_Q8))
        begin
            s1_hum_next = 15'(RH_MAX_Q8);
        end
        else
        begin
            s1_hum_next = humidity;
        end
    end

    always_comb
    begin
        s2_exp_next = 4'd8;
        for (int b = 9; b <= 14; b++)
        begin
            if (s1_hum_reg[b])
            begin
                s2_exp_next = 4'(b);
            end
        end
        s2_shift     = (32'(s1_hum_reg) << 16) >> s2_exp_next;
        s2_frac_next = s2_shift[15:0];
        s2_den_sum   = 18'(MAG_B_S) + 18'(s1_temp_reg);
    end

    assign s3_abs    = s2_prod_reg[36] ? 36'(-s2_prod_reg) : 36'(s2_prod_reg);
    assign s4_idx    = s3_pos_reg[16 +: IDX_W];
    assign s6_ln_sum = 21'(s5_exp_reg) * 21'(LN2_Q16) + 21'(s5_base_reg)
                     + 21'((33'(s5_interp_reg) + 33'd32768) >> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
            s9_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start & ~busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= d1_vld;
            s8_vld_reg <= s7_vld_reg;
            s9_vld_reg <= s8_vld_reg;
            done_reg   <= d2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_temp_reg   <= temperature;
        s1_hum_reg    <= s1_hum_next;

        s2_prod_reg   <= 37'(MAG_A_S) * 37'(s1_temp_reg);
        s2_den_reg    <= s2_den_sum[16:0];
        s2_exp_reg    <= s2_exp_next;
        s2_frac_reg   <= s2_frac_next;

        s3_num_reg    <= s3_abs + 36'(s2_den_reg >> 1);
        s3_den_reg    <= s2_den_reg;
        s3_sign_reg   <= s2_prod_reg[36];
        s3_exp_reg    <= s2_exp_reg;
        s3_pos_reg    <= PW'(s2_frac_reg) * PW'(LOG_TABLE_DEPTH);

        s4_num_reg    <= s3_num_reg;
        s4_den_reg    <= s3_den_reg;
        s4_sign_reg   <= s3_sign_reg;
        s4_exp_reg    <= s3_exp_reg;
        s4_base_reg   <= rom_lo[s4_idx];
        s4_diff_reg   <= rom_diff[s4_idx];
        s4_rem_reg    <= s3_pos_reg[15:0];

        s5_num_reg    <= s4_num_reg;
        s5_den_reg    <= s4_den_reg;
        s5_sign_reg   <= s4_sign_reg;
        s5_exp_reg    <= s4_exp_reg;
        s5_base_reg   <= s4_base_reg;
        s5_interp_reg <= 32'(s4_diff_reg) * 32'(s4_rem_reg);

        s6_num_reg    <= s5_num_reg;
        s6_den_reg    <= s5_den_reg;
        s6_sign_reg   <= s5_sign_reg;
        s6_lnr_reg    <= $signed(s6_ln_sum) - LN_MAX_S;

        s7_gamma_reg  <= s7_term + 23'($signed(d1_side[20:0]));

        s8_prod_reg   <= 39'(MAG_B_S) * 39'(s7_gamma_reg);
        s8_den_reg    <= s8_den_diff[21:0];

        s9_num_reg    <= s9_abs + 38'(s8_den_reg >> 1);
        s9_den_reg    <= s8_den_reg;
        s9_sign_reg   <= s8_prod_reg[38];

        dew_reg       <= dew_next;
    end

    dpm_div #(
        .NUM_W  (36),
        .DEN_W  (17),
        .QUO_W  (21),
        .SIDE_W (22)
    ) u_div_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_vld_reg),
        .num       (s6_num_reg),
        .den       (s6_den_reg),
        .side      ({s6_sign_reg, s6_lnr_reg}),
        .out_valid (d1_vld),
        .quo       (d1_quo),
        .side_out  (d1_side)
    );

    assign s7_term     = d1_side[21] ? -23'(d1_quo) : 23'(d1_quo);
    assign s8_den_diff = 24'(MAG_A_S) - 24'(s7_gamma_reg);
    assign s9_abs      = s8_prod_reg[38] ? 38'(-s8_prod_reg) : 38'(s8_prod_reg);

    dpm_div #(
        .NUM_W  (38),
        .DEN_W  (22),
        .QUO_W  (17),
        .SIDE_W (1)
    ) u_div_dew (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s9_vld_reg),
        .num       (s9_num_reg),
        .den       (s9_den_reg),
        .side      (s9_sign_reg),
        .out_valid (d2_vld),
        .quo       (d2_quo),
        .side_out  (d2_side)
    );

    always_comb
    begin
        dew_full = d2_side ? -18'(d2_quo) : 18'(d2_quo);
        if (dew_full < DEW_MIN_S)
        begin
            dew_next = 17'(DEW_MIN_S);
        end
        else if (dew_full > DEW_MAX_S)
        begin
            dew_next = 17'(DEW_MAX_S);
        end
        else
        begin
            dew_next = dew_full[16:0];
        end
    end

    assign done      = done_reg;
    assign dew_point = dew_reg;

endmodule
